/* rtl/core/igqr_pkg.sv */
`default_nettype none

package igqr_pkg;

    // Field and datapath widths.
    localparam int SAMPLE_W    = 32;
    localparam int QUANT_W     = 33;
    localparam int INTERCEPT_W = 40;
    localparam int GAIN_W      = 32;
    localparam int RAD_W       = 64;
    localparam int GAIN_FRAC   = 30;
    localparam int OUT_TDATA_W = 40;
    localparam int CFG_DATA_W  = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int STEP_W      = 4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_INTERCEPT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SHOCK     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_Q    = 2'd3;

    // Program addresses.
    localparam logic [STEP_W-1:0] UC_FETCH     = 4'd0;
    localparam logic [STEP_W-1:0] UC_SQ_Q      = 4'd1;
    localparam logic [STEP_W-1:0] UC_LAG_LO    = 4'd2;
    localparam logic [STEP_W-1:0] UC_LAG_HI    = 4'd3;
    localparam logic [STEP_W-1:0] UC_LAG_SCL   = 4'd4;
    localparam logic [STEP_W-1:0] UC_LAG_ACC   = 4'd5;
    localparam logic [STEP_W-1:0] UC_SQ_S      = 4'd6;
    localparam logic [STEP_W-1:0] UC_SHK_LO    = 4'd7;
    localparam logic [STEP_W-1:0] UC_SHK_HI    = 4'd8;
    localparam logic [STEP_W-1:0] UC_SHK_SCL   = 4'd9;
    localparam logic [STEP_W-1:0] UC_SHK_ACC   = 4'd10;
    localparam logic [STEP_W-1:0] UC_ROOT_INIT = 4'd11;
    localparam logic [STEP_W-1:0] UC_ROOT      = 4'd12;
    localparam logic [STEP_W-1:0] UC_EMIT      = 4'd13;

    typedef enum logic [1:0] {
        OPA_QM    = 2'd0,
        OPA_SM    = 2'd1,
        OPA_SQ_LO = 2'd2,
        OPA_SQ_HI = 2'd3
    } t_opa;

    typedef enum logic [1:0] {
        OPB_QM    = 2'd0,
        OPB_SM    = 2'd1,
        OPB_LAG   = 2'd2,
        OPB_SHOCK = 2'd3
    } t_opb;

    typedef enum logic [1:0] {
        DST_NONE = 2'd0,
        DST_SQ   = 2'd1,
        DST_LO   = 2'd2,
        DST_HI   = 2'd3
    } t_dst;

    typedef enum logic [1:0] {
        JMP_NEXT     = 2'd0,
        JMP_IF_FIRST = 2'd1,
        JMP_ALWAYS   = 2'd2
    } t_jmp;

    typedef struct packed {
        logic              fetch;
        t_opa              mul_a;
        t_opb              mul_b;
        t_dst              mul_dst;
        logic              scale;
        logic              acc;
        logic              root_init;
        logic              root_step;
        logic              emit;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_uword;

    // Control store: one word per program step.
    function automatic t_uword uc_word(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{fetch: 1'b0, mul_a: OPA_QM, mul_b: OPB_QM, mul_dst: DST_NONE,
              scale: 1'b0, acc: 1'b0, root_init: 1'b0, root_step: 1'b0,
              emit: 1'b0, jmp: JMP_NEXT, target: UC_FETCH};
        unique case (step)
            UC_FETCH: begin
                w.fetch  = 1'b1;
                w.jmp    = JMP_IF_FIRST;
                w.target = UC_EMIT;
            end
            UC_SQ_Q: begin
                w.mul_a   = OPA_QM;
                w.mul_b   = OPB_QM;
                w.mul_dst = DST_SQ;
            end
            UC_LAG_LO: begin
                w.mul_a   = OPA_SQ_LO;
                w.mul_b   = OPB_LAG;
                w.mul_dst = DST_LO;
            end
            UC_LAG_HI: begin
                w.mul_a   = OPA_SQ_HI;
                w.mul_b   = OPB_LAG;
                w.mul_dst = DST_HI;
            end
            UC_LAG_SCL: w.scale = 1'b1;
            UC_LAG_ACC: w.acc   = 1'b1;
            UC_SQ_S: begin
                w.mul_a   = OPA_SM;
                w.mul_b   = OPB_SM;
                w.mul_dst = DST_SQ;
            end
            UC_SHK_LO: begin
                w.mul_a   = OPA_SQ_LO;
                w.mul_b   = OPB_SHOCK;
                w.mul_dst = DST_LO;
            end
            UC_SHK_HI: begin
                w.mul_a   = OPA_SQ_HI;
                w.mul_b   = OPB_SHOCK;
                w.mul_dst = DST_HI;
            end
            UC_SHK_SCL:   w.scale     = 1'b1;
            UC_SHK_ACC:   w.acc       = 1'b1;
            UC_ROOT_INIT: w.root_init = 1'b1;
            UC_ROOT:      w.root_step = 1'b1;
            UC_EMIT: begin
                w.emit   = 1'b1;
                w.jmp    = JMP_ALWAYS;
                w.target = UC_FETCH;
            end
            default: begin
                w.jmp    = JMP_ALWAYS;
                w.target = UC_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/indirect_garch_quantile_recursion.sv */
`default_nettype none

// Channel   Direction  Handshake                  Payload
// --------  ---------  -------------------------  ----------------------------------------
// s (in)    slave      i_s_tvalid / o_s_tready    tdata: sample; tuser: series_start
// m (out)   master     o_m_tvalid / i_m_tready    tdata: quantile, zero pad; tuser: clipped
// cfg       slave      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// A continuing item runs one fetch, two square-and-scale passes of five steps each on the
// shared 32x32 multiplier, one root setup, 32 steps of the bit-by-bit square root and one
// emit. The first item of a series runs only the fetch and emit steps.
// Reset is synchronous and active low; it clears the sequencer, the output valid, the
// configuration registers and the recursion state. The program holds in its emit step
// while the output register is full and not read, and the input is taken only in the fetch step.
//
// The block is driven by a small control store. Each step's control word selects the
// multiplier operands and destination, enables the scale, accumulate and root units, and
// says whether to fall through or jump. A step counter walks the program; the fetch step
// jumps straight to emit when the item opens a series.
module indirect_garch_quantile_recursion (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // [31:0] sample
    input  wire logic        i_s_tuser,   // [0] series_start

    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [39:0]      o_m_tdata,   // [32:0] quantile, [39:33] zero
    output logic             o_m_tuser,   // [0] clipped

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [39:0] i_cfg_data
);

    // Configuration registers.
    logic [igqr_pkg::INTERCEPT_W-1:0] r_intercept;
    logic [igqr_pkg::GAIN_W-1:0]      r_lag_gain;
    logic [igqr_pkg::GAIN_W-1:0]      r_shock_gain;
    logic [igqr_pkg::SAMPLE_W-1:0]    r_init_q;

    // Recursion state.
    logic [igqr_pkg::QUANT_W-1:0]  r_prior_q;
    logic [igqr_pkg::SAMPLE_W-1:0] r_prior_s;
    logic                          r_open;

    // Item in flight.
    logic [igqr_pkg::SAMPLE_W-1:0] r_cur_s;
    logic                          r_first;

    // Sequencer.
    logic [igqr_pkg::STEP_W-1:0] r_step;
    logic [igqr_pkg::STEP_W-1:0] n_step;
    igqr_pkg::t_uword            uw;

    // Datapath registers.
    logic [igqr_pkg::RAD_W-1:0] r_sq;
    logic [igqr_pkg::RAD_W-1:0] r_plo;
    logic [igqr_pkg::RAD_W-1:0] r_phi;
    logic [igqr_pkg::RAD_W-1:0] r_term;
    logic [igqr_pkg::RAD_W-1:0] r_rad;
    logic                       r_sat;
    logic [igqr_pkg::RAD_W-1:0] r_rem;
    logic [igqr_pkg::RAD_W-1:0] r_res;
    logic [igqr_pkg::RAD_W-1:0] r_bit;

    // Output register.
    logic                           r_m_valid;
    logic [igqr_pkg::QUANT_W-1:0]   r_m_quant;
    logic                           r_m_clip;

    logic in_acc;
    logic first_now;
    logic out_blocked;
    logic stall;

    logic [igqr_pkg::QUANT_W-1:0]  q_abs;
    logic [31:0]                   qm;
    logic [igqr_pkg::SAMPLE_W-1:0] sm;
    logic [31:0]                   mul_a;
    logic [31:0]                   mul_b;
    logic [63:0]                   prod;

    logic [63:0] scl_hi;
    logic [95:0] scl_full;
    logic [64:0] acc_sum;
    logic [64:0] root_try;
    logic        root_ge;

    logic [igqr_pkg::QUANT_W-1:0] emit_q;
    logic                         emit_clip;

    assign uw          = igqr_pkg::uc_word(r_step);
    assign o_s_tready  = uw.fetch;
    assign in_acc      = i_s_tvalid && uw.fetch;
    assign first_now   = i_s_tuser || !r_open;
    assign out_blocked = r_m_valid && !i_m_tready;

    // The fetch step waits for an item, emit waits for room, the root step loops.
    assign stall = (uw.fetch && !i_s_tvalid) || (uw.emit && out_blocked) ||
                   (uw.root_step && !r_bit[0]);

    always_comb begin
        n_step = r_step + igqr_pkg::STEP_W'(1);
        if (stall) begin
            n_step = r_step;
        end else if (uw.jmp == igqr_pkg::JMP_ALWAYS) begin
            n_step = uw.target;
        end else if (uw.jmp == igqr_pkg::JMP_IF_FIRST && first_now) begin
            n_step = uw.target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= igqr_pkg::UC_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    // Configuration writes are taken in any cycle; bits above a register's width drop.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_intercept  <= '0;
            r_lag_gain   <= '0;
            r_shock_gain <= '0;
            r_init_q     <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                igqr_pkg::CFG_INTERCEPT: r_intercept  <= i_cfg_data[igqr_pkg::INTERCEPT_W-1:0];
                igqr_pkg::CFG_LAG_GAIN:  r_lag_gain   <= i_cfg_data[igqr_pkg::GAIN_W-1:0];
                igqr_pkg::CFG_SHOCK:     r_shock_gain <= i_cfg_data[igqr_pkg::GAIN_W-1:0];
                igqr_pkg::CFG_INIT_Q:    r_init_q     <= i_cfg_data[igqr_pkg::SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    // Magnitudes of the previous quantile and sample. Only squares are used, so the sign
    // drops out; a quantile magnitude of 2^32 is clamped to 2^32-1.
    assign q_abs = r_prior_q[igqr_pkg::QUANT_W-1] ? (~r_prior_q + igqr_pkg::QUANT_W'(1))
                                                   : r_prior_q;
    assign qm    = q_abs[igqr_pkg::QUANT_W-1] ? '1 : q_abs[31:0];
    assign sm    = r_prior_s[igqr_pkg::SAMPLE_W-1] ? (~r_prior_s + igqr_pkg::SAMPLE_W'(1))
                                                    : r_prior_s;

    // Shared 32x32 multiplier.
    always_comb begin
        case (uw.mul_a)
            igqr_pkg::OPA_QM:    mul_a = qm;
            igqr_pkg::OPA_SM:    mul_a = sm;
            igqr_pkg::OPA_SQ_LO: mul_a = r_sq[31:0];
            igqr_pkg::OPA_SQ_HI: mul_a = r_sq[63:32];
            default:             mul_a = qm;
        endcase
        case (uw.mul_b)
            igqr_pkg::OPB_QM:    mul_b = qm;
            igqr_pkg::OPB_SM:    mul_b = sm;
            igqr_pkg::OPB_LAG:   mul_b = r_lag_gain;
            igqr_pkg::OPB_SHOCK: mul_b = r_shock_gain;
            default:             mul_b = qm;
        endcase
    end

    assign prod = {32'd0, mul_a} * {32'd0, mul_b};

    // Full 96-bit gain product from the two partial products; the scaled term drops the
    // 30 gain fraction bits and saturates when anything is left above 64 bits.
    assign scl_hi   = r_phi + {32'd0, r_plo[63:32]};
    assign scl_full = {scl_hi, r_plo[31:0]};
    assign acc_sum  = {1'b0, r_rad} + {1'b0, r_term};

    // One step of the bit-pair square root.
    assign root_try = {1'b0, r_res} + {1'b0, r_bit};
    assign root_ge  = {1'b0, r_rem} >= root_try;

    always_ff @(posedge i_clk) begin
        case (uw.mul_dst)
            igqr_pkg::DST_SQ: r_sq  <= prod;
            igqr_pkg::DST_LO: r_plo <= prod;
            igqr_pkg::DST_HI: r_phi <= prod;
            default: ;
        endcase

        if (in_acc) begin
            r_cur_s <= i_s_tdata;
            r_first <= first_now;
            r_rad   <= {24'd0, r_intercept};
            r_sat   <= 1'b0;
        end

        if (uw.scale) begin
            if (scl_full[95:94] != 2'b00) begin
                r_term <= '1;
                r_sat  <= 1'b1;
            end else begin
                r_term <= scl_full[93:30];
            end
        end

        if (uw.acc) begin
            if (acc_sum[64]) begin
                r_rad <= '1;
                r_sat <= 1'b1;
            end else begin
                r_rad <= acc_sum[63:0];
            end
        end

        if (uw.root_init) begin
            r_rem <= r_sat ? '1 : r_rad;
            r_res <= '0;
            r_bit <= {2'b01, 62'd0};
        end

        if (uw.root_step) begin
            if (root_ge) begin
                r_rem <= r_rem - root_try[63:0];
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    // Result of this item: the initial quantile opens a series, else the root.
    assign emit_q    = r_first ? {r_init_q[igqr_pkg::SAMPLE_W-1], r_init_q}
                               : {1'b0, r_res[31:0]};
    assign emit_clip = r_first ? 1'b0 : r_sat;

    // A new result loads the output register in the same cycle that the old one leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_prior_q <= '0;
            r_prior_s <= '0;
            r_open    <= 1'b0;
        end else begin
            if (uw.emit && !out_blocked) begin
                r_m_valid <= 1'b1;
                r_prior_q <= emit_q;
                r_prior_s <= r_cur_s;
                r_open    <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.emit && !out_blocked) begin
            r_m_quant <= emit_q;
            r_m_clip  <= emit_clip;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(igqr_pkg::OUT_TDATA_W - igqr_pkg::QUANT_W)'(0), r_m_quant};
    assign o_m_tuser  = r_m_clip;

endmodule

`default_nettype wire
